// ----- sv/htq_pkg.sv -----
package htq_pkg;

    localparam int HeapDepthDef = 64;
    localparam int TimerIdsDef  = 32;
    localparam int DeadlineW    = 64;
    localparam int IdW          = 5;
    localparam int CountW       = 6;

    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_CANCEL   = 2'd1,
        OP_POLL     = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_FIRED  = 1'b1;

    function automatic logic entry_before(
        input logic [DeadlineW-1:0] da,
        input logic [IdW-1:0]       ia,
        input logic [DeadlineW-1:0] db,
        input logic [IdW-1:0]       ib
    );
        return (da < db) || ((da == db) && (ia < ib));
    endfunction

endpackage

// ----- sv/htq_heap_ram.sv -----
module htq_heap_ram
    import htq_pkg::*;
#(
    parameter int HEAP_DEPTH = HeapDepthDef,
    localparam int AW = $clog2(HEAP_DEPTH)
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [DeadlineW-1:0] wdeadline,
    input  logic [IdW-1:0]       wid,
    input  logic [AW-1:0]        raddr,
    output logic [DeadlineW-1:0] rdeadline,
    output logic [IdW-1:0]       rid
);

    logic [DeadlineW+IdW-1:0] mem [HEAP_DEPTH];
    logic [DeadlineW+IdW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wdeadline, wid};
        end
        rdata_reg <= mem[raddr];
    end

    assign rdeadline = rdata_reg[DeadlineW+IdW-1:IdW];
    assign rid       = rdata_reg[IdW-1:0];

endmodule

// ----- sv/heap_timer_queue_logical_clock.sv -----
// channel | dir | tdata (low bit up)                                        | tuser | tlast
// s_axis  | in  | op[1:0] timer_id[6:2] deadline[70:7] ready_req[71]       | -     | -
// m_axis  | out | clock_now[63:0] ready_echo[64] fired_count[70:65]        | kind  | last
//         |     | fired_id[75:71] overflow_seen[76]                        |       |
//
// Schedule: sift-up reads (S_UP_RD), compares/writes (S_UP_CMP) per level; root: S_UP_WR.
// Remove: S_RM_LAST, S_RM_LD, then left read, right read and compare/write per level.
// A poll: a head read and check per head, one remove per stale or expired entry, then one
// result per cycle while m_axis_tready is high.
// s_axis_tready is high only when idle; cancel and unused codes stay idle.
// rst_n is asynchronous; heap memory is not cleared, size, flags, clock and overflow reset.
module heap_timer_queue_logical_clock
    import htq_pkg::*;
#(
    parameter int HEAP_DEPTH = HeapDepthDef,
    parameter int TIMER_IDS  = TimerIdsDef
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // op, timer_id, deadline, ready_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // clock_now, ready_echo, fired_count, fired_id,
                                       // overflow_seen
    output logic        m_axis_tuser,  // kind
    output logic        m_axis_tlast
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int SW = $clog2(HEAP_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_UP_WR,
        S_HEAD_RD, S_HEAD_CHK,
        S_RM_LAST, S_RM_LD, S_RM_L, S_RM_R, S_RM_CMP, S_RM_WR,
        S_HDR, S_FIRE
    } state_t;

    state_t state_reg;
    logic [SW-1:0]        size_reg;
    logic [TIMER_IDS-1:0] active_reg;
    logic [DeadlineW-1:0] clock_reg;
    logic                 ovf_reg;
    logic [AW-1:0]        pos_reg;
    logic [DeadlineW-1:0] d_reg;
    logic [IdW-1:0]       id_reg;
    logic [DeadlineW-1:0] cd_reg;
    logic [IdW-1:0]       cid_reg;
    logic                 right_reg;
    logic                 ready_reg;
    logic                 phase_reg;
    logic [IdW-1:0]       fifo_reg [TIMER_IDS];
    logic [CountW-1:0]    k_reg;
    logic [CountW-1:0]    ptr_reg;

    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [DeadlineW-1:0] wdeadline, rdeadline;
    logic [IdW-1:0]       wid, rid;

    htq_heap_ram #(.HEAP_DEPTH(HEAP_DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdeadline(wdeadline), .wid(wid),
        .raddr(raddr), .rdeadline(rdeadline), .rid(rid)
    );

    logic [1:0]           in_op;
    logic [IdW-1:0]       in_id;
    logic [DeadlineW-1:0] in_d;
    logic                 in_rdy;
    assign in_op  = s_axis_tdata[1:0];
    assign in_id  = s_axis_tdata[6:2];
    assign in_d   = s_axis_tdata[70:7];
    assign in_rdy = s_axis_tdata[71];

    logic [AW-1:0] up_par;
    logic [AW:0]   lchild;
    logic [AW:0]   rchild;
    assign up_par = (pos_reg - AW'(1)) >> 1;
    assign lchild = {pos_reg, 1'b1};
    assign rchild = lchild + (AW+1)'(1);

    logic                 has_left, has_right;
    logic                 up_move, take_right, dn_move;
    logic [DeadlineW-1:0] ch_d;
    logic [IdW-1:0]       ch_id;
    assign has_left   = 32'(lchild) < 32'(size_reg);
    assign has_right  = 32'(rchild) < 32'(size_reg);
    assign up_move    = entry_before(d_reg, id_reg, rdeadline, rid);
    assign take_right = right_reg && entry_before(rdeadline, rid, cd_reg, cid_reg);
    assign ch_d       = take_right ? rdeadline : cd_reg;
    assign ch_id      = take_right ? rid : cid_reg;
    assign dn_move    = entry_before(ch_d, ch_id, d_reg, id_reg);

    // clock after the optional jump to the head deadline
    logic [DeadlineW-1:0] eff_clock;
    logic                 head_stale, pop_now, fire_now;
    assign eff_clock  = (!phase_reg && !ready_reg && rdeadline > clock_reg) ?
                        rdeadline : clock_reg;
    assign head_stale = !phase_reg && !active_reg[rid];
    assign pop_now    = (state_reg == S_HEAD_CHK) && !head_stale && (rdeadline <= eff_clock);
    assign fire_now   = pop_now && active_reg[rid] && (32'(k_reg) < TIMER_IDS);

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        we        = 1'b0;
        waddr     = pos_reg;
        wdeadline = d_reg;
        wid       = id_reg;
        raddr     = '0;
        case (state_reg)
            S_UP_RD:   raddr = up_par;
            S_UP_CMP:
            begin
                we = 1'b1;
                if (up_move)
                begin
                    wdeadline = rdeadline;
                    wid       = rid;
                end
            end
            S_UP_WR:   we = 1'b1;
            S_RM_LAST: raddr = AW'(size_reg);
            S_RM_L:    raddr = lchild[AW-1:0];
            S_RM_R:    raddr = rchild[AW-1:0];
            S_RM_CMP:
            begin
                we = 1'b1;
                if (dn_move)
                begin
                    wdeadline = ch_d;
                    wid       = ch_id;
                end
            end
            S_RM_WR:   we = (size_reg != '0);
            default: ;
        endcase
    end

    assign m_axis_tvalid = (state_reg == S_HDR) || (state_reg == S_FIRE);
    assign m_axis_tuser  = (state_reg == S_FIRE) ? KIND_FIRED : KIND_HEADER;
    assign m_axis_tlast  = (state_reg == S_HDR) ? (k_reg == '0) :
                           (ptr_reg + CountW'(1) == k_reg);
    assign m_axis_tdata  = {
        3'd0, ovf_reg,
        (state_reg == S_FIRE) ? fifo_reg[ptr_reg[IdW-1:0]] : {IdW{1'b0}},
        k_reg, ready_reg, clock_reg
    };

    always_ff @(posedge clk)
    begin
        if (fire_now)
        begin
            fifo_reg[k_reg[IdW-1:0]] <= rid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            size_reg   <= '0;
            active_reg <= '0;
            clock_reg  <= '0;
            ovf_reg    <= 1'b0;
            pos_reg    <= '0;
            d_reg      <= '0;
            id_reg     <= '0;
            cd_reg     <= '0;
            cid_reg    <= '0;
            right_reg  <= 1'b0;
            ready_reg  <= 1'b0;
            phase_reg  <= 1'b0;
            k_reg      <= '0;
            ptr_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (s_axis_tvalid)
                    begin
                        case (in_op)
                            OP_SCHEDULE:
                                if (32'(in_id) < TIMER_IDS)
                                begin
                                    if (32'(size_reg) >= HEAP_DEPTH)
                                    begin
                                        ovf_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        active_reg[in_id] <= 1'b1;
                                        pos_reg   <= AW'(size_reg);
                                        size_reg  <= size_reg + 1'b1;
                                        d_reg     <= in_d;
                                        id_reg    <= in_id;
                                        state_reg <= (size_reg == '0) ? S_UP_WR : S_UP_RD;
                                    end
                                end
                            OP_CANCEL:
                                if (32'(in_id) < TIMER_IDS)
                                begin
                                    active_reg[in_id] <= 1'b0;
                                end
                            OP_POLL:
                            begin
                                ready_reg <= in_rdy;
                                k_reg     <= '0;
                                phase_reg <= 1'b0;
                                state_reg <= S_HEAD_RD;
                            end
                            default: ;
                        endcase
                    end
                S_UP_RD: state_reg <= S_UP_CMP;
                S_UP_CMP:
                    if (up_move)
                    begin
                        pos_reg   <= up_par;
                        state_reg <= (up_par == '0) ? S_UP_WR : S_UP_RD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                S_UP_WR: state_reg <= S_IDLE;
                S_HEAD_RD: state_reg <= (size_reg == '0) ? S_HDR : S_HEAD_CHK;
                S_HEAD_CHK:
                    if (head_stale)
                    begin
                        size_reg  <= size_reg - 1'b1;
                        state_reg <= S_RM_LAST;
                    end
                    else
                    begin
                        phase_reg <= 1'b1;
                        clock_reg <= eff_clock;
                        if (pop_now)
                        begin
                            size_reg  <= size_reg - 1'b1;
                            state_reg <= S_RM_LAST;
                            if (fire_now)
                            begin
                                active_reg[rid] <= 1'b0;
                                k_reg <= k_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            state_reg <= S_HDR;
                        end
                    end
                S_RM_LAST: state_reg <= S_RM_LD;
                S_RM_LD:
                begin
                    d_reg     <= rdeadline;
                    id_reg    <= rid;
                    pos_reg   <= '0;
                    state_reg <= S_RM_L;
                end
                S_RM_L: state_reg <= has_left ? S_RM_R : S_RM_WR;
                S_RM_R:
                begin
                    cd_reg    <= rdeadline;
                    cid_reg   <= rid;
                    right_reg <= has_right;
                    state_reg <= S_RM_CMP;
                end
                S_RM_CMP:
                    if (dn_move)
                    begin
                        pos_reg   <= take_right ? rchild[AW-1:0] : lchild[AW-1:0];
                        state_reg <= S_RM_L;
                    end
                    else
                    begin
                        state_reg <= S_HEAD_RD;
                    end
                S_RM_WR: state_reg <= S_HEAD_RD;
                S_HDR:
                    if (m_axis_tready)
                    begin
                        ptr_reg   <= '0;
                        state_reg <= (k_reg == '0) ? S_IDLE : S_FIRE;
                    end
                S_FIRE:
                    if (m_axis_tready)
                    begin
                        if (ptr_reg + CountW'(1) == k_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            ptr_reg <= ptr_reg + 1'b1;
                        end
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
        $stable(m_axis_tuser) && $stable(m_axis_tlast));
    a_size_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(size_reg) <= HEAP_DEPTH);
    a_in_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid));
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(k_reg) <= TIMER_IDS);

endmodule
